// ----- design/p2nnd_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and size helpers for the power-of-two downscaler.
package p2nnd_pkg;

  // Dimension and accumulator widths
  localparam int DIM_BITS   = 12;
  localparam int ACC_BITS   = 2 * DIM_BITS - 1;
  localparam int SHIFT_BITS = 4;
  localparam int PIX_BITS   = 8;
  localparam int ADDR_BITS  = 4;
  localparam int DATA_BITS  = 32;

  // Largest target size as a shift, per quality setting
  localparam logic [SHIFT_BITS-1:0] CAP_SHIFT_HIGH   = SHIFT_BITS'(11);
  localparam logic [SHIFT_BITS-1:0] CAP_SHIFT_MEDIUM = SHIFT_BITS'(9);
  localparam logic [SHIFT_BITS-1:0] CAP_SHIFT_LOW    = SHIFT_BITS'(8);

  // Quality selector codes
  typedef enum logic [1:0] {
    QUAL_HIGH   = 2'd0,
    QUAL_MEDIUM = 2'd1,
    QUAL_LOW    = 2'd2
  } quality_t;

  // Register indexes (word address paddr[3:2])
  typedef enum logic [1:0] {
    REG_SRC_WIDTH  = 2'd0,
    REG_SRC_HEIGHT = 2'd1,
    REG_QUALITY    = 2'd2,
    REG_ALPHA_EN   = 2'd3
  } reg_index_t;

  // One result item
  typedef struct packed {
    logic [PIX_BITS-1:0] red;
    logic [PIX_BITS-1:0] green;
    logic [PIX_BITS-1:0] blue;
    logic [PIX_BITS-1:0] alpha;
    logic                eor;
    logic                eof;
    logic [DIM_BITS-1:0] dst_w;
    logic [DIM_BITS-1:0] dst_h;
  } out_item_t;

  // log2 of the target size: top set bit of the source size, capped by quality;
  // sizes below two give a target of one
  function automatic logic [SHIFT_BITS-1:0] target_shift(
    input logic [DIM_BITS-1:0] src,
    input logic [1:0]          quality
  );
    logic [SHIFT_BITS-1:0] msb;
    logic [SHIFT_BITS-1:0] cap;
    msb = '0;
    for (int i = 1; i < DIM_BITS; i++) begin
      if (src[i]) begin
        msb = SHIFT_BITS'(i);
      end
    end
    case (quality)
      QUAL_HIGH:   cap = CAP_SHIFT_HIGH;
      QUAL_LOW:    cap = CAP_SHIFT_LOW;
      QUAL_MEDIUM: cap = CAP_SHIFT_MEDIUM;
      default:     cap = CAP_SHIFT_MEDIUM;
    endcase
    target_shift = (msb > cap) ? cap : msb;
  endfunction

endpackage

// ----- design/pow2_nearest_neighbor_downscaler.sv -----
`timescale 1ns / 1ps
// Top level: nearest-neighbour power-of-two downscaler with APB configuration.
// A selected pixel is registered, into the skid entry while the output is stalled.
// Throughput: one source pixel per cycle (compare against a shifted accumulator, two adds).
// Result register plus one skid entry; the input stalls only while the skid is full.
// Reset (rst, synchronous, active high) clears the counters and empties the output;
// registers return to width 2, height 2, high quality, alpha present.
module pow2_nearest_neighbor_downscaler (
  input  logic                                clk,
  input  logic                                rst,
  // APB configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [p2nnd_pkg::ADDR_BITS-1:0]     paddr,
  input  logic [p2nnd_pkg::DATA_BITS-1:0]     pwdata,
  output logic [p2nnd_pkg::DATA_BITS-1:0]     prdata,
  output logic                                pready,
  // Source pixel stream
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [p2nnd_pkg::PIX_BITS-1:0]      in_red,
  input  logic [p2nnd_pkg::PIX_BITS-1:0]      in_green,
  input  logic [p2nnd_pkg::PIX_BITS-1:0]      in_blue,
  input  logic [p2nnd_pkg::PIX_BITS-1:0]      in_alpha,
  // Scaled pixel stream
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [p2nnd_pkg::PIX_BITS-1:0]      out_red,
  output logic [p2nnd_pkg::PIX_BITS-1:0]      out_green,
  output logic [p2nnd_pkg::PIX_BITS-1:0]      out_blue,
  output logic [p2nnd_pkg::PIX_BITS-1:0]      out_alpha,
  output logic                                end_of_row,
  output logic                                end_of_frame,
  output logic [p2nnd_pkg::DIM_BITS-1:0]      dst_width,
  output logic [p2nnd_pkg::DIM_BITS-1:0]      dst_height
);

  localparam int DB = p2nnd_pkg::DIM_BITS;
  localparam int AB = p2nnd_pkg::ACC_BITS;
  localparam int SB = p2nnd_pkg::SHIFT_BITS;

  // Configuration registers
  logic [DB-1:0] src_width;
  logic [DB-1:0] src_height;
  logic [1:0]    quality_mode;
  logic          alpha_enable;

  // Position state
  logic [DB-1:0] source_column, source_column_next;
  logic [DB-1:0] source_row, source_row_next;
  logic [DB-1:0] output_column, output_column_next;
  logic [DB-1:0] output_row, output_row_next;
  logic [AB-1:0] column_accumulator, column_accumulator_next;
  logic [AB-1:0] row_accumulator, row_accumulator_next;

  // Output buffer
  p2nnd_pkg::out_item_t out_item, skid_item, result;
  logic                 skid_valid;

  logic          cfg_write;
  logic [DB-1:0] sw, sh;
  logic [SB-1:0] wsh, hsh;
  logic [DB-1:0] dw, dh;
  logic          row_hit, col_hit, hit;
  logic          in_fire, out_fire, out_free;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      src_width    <= DB'(2);
      src_height   <= DB'(2);
      quality_mode <= p2nnd_pkg::QUAL_HIGH;
      alpha_enable <= 1'b1;
    end else if (cfg_write) begin
      case (paddr[3:2])
        p2nnd_pkg::REG_SRC_WIDTH:  src_width    <= pwdata[DB-1:0];
        p2nnd_pkg::REG_SRC_HEIGHT: src_height   <= pwdata[DB-1:0];
        p2nnd_pkg::REG_QUALITY:    quality_mode <= pwdata[1:0];
        p2nnd_pkg::REG_ALPHA_EN:   alpha_enable <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    case (paddr[3:2])
      p2nnd_pkg::REG_SRC_WIDTH:  prdata = p2nnd_pkg::DATA_BITS'(src_width);
      p2nnd_pkg::REG_SRC_HEIGHT: prdata = p2nnd_pkg::DATA_BITS'(src_height);
      p2nnd_pkg::REG_QUALITY:    prdata = p2nnd_pkg::DATA_BITS'(quality_mode);
      p2nnd_pkg::REG_ALPHA_EN:   prdata = p2nnd_pkg::DATA_BITS'(alpha_enable);
      default:                   prdata = '0;
    endcase
  end

  // Target sizes; a zero size counts as one
  assign sw  = (src_width == '0) ? DB'(1) : src_width;
  assign sh  = (src_height == '0) ? DB'(1) : src_height;
  assign wsh = p2nnd_pkg::target_shift(sw, quality_mode);
  assign hsh = p2nnd_pkg::target_shift(sh, quality_mode);
  assign dw  = DB'(1) << wsh;
  assign dh  = DB'(1) << hsh;

  // Selection: source index matches output index times source size over target size
  assign row_hit = (output_row < dh) &&
                   (AB'(source_row) == (row_accumulator >> hsh));
  assign col_hit = (output_column < dw) &&
                   (AB'(source_column) == (column_accumulator >> wsh));
  assign hit     = row_hit && col_hit;

  // Result of the current transfer
  always_comb begin
    result.red   = in_red;
    result.green = in_green;
    result.blue  = in_blue;
    result.alpha = alpha_enable ? in_alpha : '0;
    result.eor   = (output_column == dw - DB'(1));
    result.eof   = result.eor && (output_row == dh - DB'(1));
    result.dst_w = dw;
    result.dst_h = dh;
  end

  // Counter update
  always_comb begin
    source_column_next      = source_column + DB'(1);
    source_row_next         = source_row;
    output_column_next      = output_column;
    output_row_next         = output_row;
    column_accumulator_next = column_accumulator;
    row_accumulator_next    = row_accumulator;
    if (hit) begin
      output_column_next      = output_column + DB'(1);
      column_accumulator_next = column_accumulator + AB'(sw);
    end
    if (source_column >= sw - DB'(1)) begin
      source_column_next      = '0;
      output_column_next      = '0;
      column_accumulator_next = '0;
      if (row_hit) begin
        output_row_next      = output_row + DB'(1);
        row_accumulator_next = row_accumulator + AB'(sh);
      end
      if (source_row >= sh - DB'(1)) begin
        source_row_next      = '0;
        output_row_next      = '0;
        row_accumulator_next = '0;
      end else begin
        source_row_next = source_row + DB'(1);
      end
    end
  end

  assign in_stall = skid_valid;
  assign in_fire  = in_valid && !in_stall;
  assign out_fire = out_valid && !out_stall;
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_column      <= '0;
      source_row         <= '0;
      output_column      <= '0;
      output_row         <= '0;
      column_accumulator <= '0;
      row_accumulator    <= '0;
    end else if (in_fire) begin
      source_column      <= source_column_next;
      source_row         <= source_row_next;
      output_column      <= output_column_next;
      output_row         <= output_row_next;
      column_accumulator <= column_accumulator_next;
      row_accumulator    <= row_accumulator_next;
    end
  end

  // Result register and skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_fire) begin
        out_item   <= skid_item;
        skid_valid <= 1'b0;
      end
    end else if (in_fire && hit) begin
      if (out_free) begin
        out_item  <= result;
        out_valid <= 1'b1;
      end else begin
        skid_item  <= result;
        skid_valid <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid <= 1'b0;
    end
  end

  assign out_red      = out_item.red;
  assign out_green    = out_item.green;
  assign out_blue     = out_item.blue;
  assign out_alpha    = out_item.alpha;
  assign end_of_row   = out_item.eor;
  assign end_of_frame = out_item.eof;
  assign dst_width    = out_item.dst_w;
  assign dst_height   = out_item.dst_h;

endmodule
